@@ design/ktss_pkg.sv @@
`default_nettype none
package ktss_pkg;

	localparam int DRAW_BITS = 32;

	localparam logic [2:0] REQ_APPEND  = 3'd0;
	localparam logic [2:0] REQ_SHUFFLE = 3'd1;
	localparam logic [2:0] REQ_SORT    = 3'd2;
	localparam logic [2:0] REQ_TOP     = 3'd3;
	localparam logic [2:0] REQ_DUMP    = 3'd4;
	localparam logic [2:0] REQ_FIND    = 3'd5;
	localparam logic [2:0] REQ_REMOVE  = 3'd6;
	localparam logic [2:0] REQ_NONE    = 3'd7;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] key_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] key_out;
		logic [5:0]  position;
		logic [6:0]  live_count;
		logic        last;
	} res_t;

	// one xorshift32 step
	function automatic logic [DRAW_BITS-1:0] xorshift(input logic [DRAW_BITS-1:0] x);
		logic [DRAW_BITS-1:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

endpackage
`default_nettype wire

@@ design/ktss_ram.sv @@
`default_nettype none
module ktss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/ktss_mod.sv @@
`default_nettype none
module ktss_mod
	import ktss_pkg::*;
#(
	parameter int W = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DRAW_BITS-1:0] dividend,
	input  wire logic [W-1:0]         divisor,
	output logic                      done,
	output logic      [W-1:0]         rem
);
	localparam int CNT_W = $clog2(DRAW_BITS + 1);

	logic [DRAW_BITS-1:0] num_q;
	logic [W-1:0]         div_q;
	logic [W-1:0]         rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [W:0]           trial;

	// restoring remainder, one dividend bit a cycle
	assign trial = {rem_q, num_q[DRAW_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DRAW_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, div_q}) begin
				rem_q <= W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= W'(trial);
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < div_q)
		else $error("remainder not below divisor");
endmodule
`default_nettype wire

@@ design/key_table_shuffle_sort_search.sv @@
`default_nettype none
// channel   direction  handshake                    word
// req       in         start high while busy low    req_t (req_type, key_in)
// res       out        res_strobe, one cycle        res_t (status .. last)
// cfg       in         cfg_valid and cfg_ready      rng_seed
//
// append and error replies: result registered at acceptance; top passes through S_TOP first
// dump, find, remove and sort scan the live entries of the table
// shuffle: each draw waits on the bit-serial remainder unit
// one table read per cycle through the single ram read port
// reset clears the count and loads seed 1; no clearing pass over the table
// the receiver cannot stall: every result is shown for exactly one cycle
module key_table_shuffle_sort_search
	import ktss_pkg::*;
#(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        req,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	output logic             res_strobe,
	output res_t             res
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_TOP       = 4'd1;
	localparam logic [3:0] S_SCAN      = 4'd2;
	localparam logic [3:0] S_REM       = 4'd3;
	localparam logic [3:0] S_SORT_NEXT = 4'd4;
	localparam logic [3:0] S_SWAP_A    = 4'd5;
	localparam logic [3:0] S_SWAP_B    = 4'd6;
	localparam logic [3:0] S_SH_DRAW   = 4'd7;
	localparam logic [3:0] S_SH_MOD    = 4'd8;
	localparam logic [3:0] S_SH_RD1    = 4'd9;
	localparam logic [3:0] S_SH_RD2    = 4'd10;
	localparam logic [3:0] S_SH_WR1    = 4'd11;
	localparam logic [3:0] S_SH_WR2    = 4'd12;

	logic [3:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [31:0]         rng_q;
	logic [2:0]          op_q;
	logic [KEY_BITS-1:0] key_q;

	// scan pipeline: read pointer and the index of the word arriving
	logic [CW-1:0]       ra_q;
	logic                rv_s1;
	logic [AW-1:0]       ri_s1;

	// find: one match held back so the final one can carry last
	logic                pend_q;
	logic [AW-1:0]       pend_pos_q;
	logic [KEY_BITS-1:0] pend_key_q;

	// selection sort
	logic [CW-1:0]       sort_i_q;
	logic                first_q;
	logic [KEY_BITS-1:0] min_q;
	logic [AW-1:0]       minpos_q;
	logic [KEY_BITS-1:0] ival_q;

	// shuffle
	logic [AW-1:0]       sh_i_q;
	logic [AW-1:0]       r_q;
	logic [KEY_BITS-1:0] vr_q;

	logic                res_strobe_q;
	res_t                res_q;

	logic                accept;
	logic                issue;
	logic                drained;
	logic                rem_hit;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [KEY_BITS-1:0] wdata;
	logic [AW-1:0]       raddr;
	logic [KEY_BITS-1:0] rdata;
	logic [31:0]         draw;
	logic                mod_start;
	logic                mod_done;
	logic [CW-1:0]       mod_rem;
	logic [KEY_BITS-1:0] key_new;
	logic [1:0]          idle_status;
	logic [6:0]          idle_live;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign issue     = (ra_q < count_q);
	assign drained   = !issue && !rv_s1;
	assign rem_hit   = rv_s1 && op_q == REQ_REMOVE && rdata == key_q;
	assign draw      = xorshift(rng_q);
	assign mod_start = (state_q == S_SH_DRAW);
	assign key_new   = KEY_BITS'(req.key_in);

	// status and count of a reply decided at acceptance
	always_comb begin
		idle_status = STAT_OK;
		idle_live   = 7'(count_q);
		if (req.req_type == REQ_APPEND) begin
			if (count_q < CW'(DEPTH)) begin
				idle_live = 7'(count_q + 1'b1);
			end else begin
				idle_status = STAT_FULL;
			end
		end else if (count_q == '0) begin
			idle_status = STAT_EMPTY;
		end
	end

	// read address
	always_comb begin
		unique case (state_q)
			S_SH_RD1: raddr = r_q;
			S_SH_RD2: raddr = sh_i_q;
			S_SCAN, S_REM: raddr = ra_q[AW-1:0];
			default: raddr = AW'(count_q - 1'b1);
		endcase
	end

	// write port
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rdata;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.req_type == REQ_APPEND && count_q < CW'(DEPTH)) begin
					we    = 1'b1;
					waddr = count_q[AW-1:0];
					wdata = key_new;
				end
			end
			S_REM: begin
				we    = rv_s1;
				waddr = ri_s1 - 1'b1;
			end
			S_SWAP_A: begin
				we    = 1'b1;
				waddr = sort_i_q[AW-1:0];
				wdata = min_q;
			end
			S_SWAP_B: begin
				we    = 1'b1;
				waddr = minpos_q;
				wdata = ival_q;
			end
			S_SH_WR1: begin
				we    = 1'b1;
				waddr = r_q;
			end
			S_SH_WR2: begin
				we    = 1'b1;
				waddr = sh_i_q;
				wdata = vr_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	ktss_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	ktss_mod #(
		.W(CW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(draw),
		.divisor (CW'(sh_i_q) + 1'b1),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rng_q        <= 32'd1;
			rv_s1        <= 1'b0;
			pend_q       <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			res_strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						rng_q <= cfg_data;
					end
					if (accept && req.req_type != REQ_NONE) begin
						if (req.req_type == REQ_APPEND) begin
							res_strobe_q <= 1'b1;
							if (count_q < CW'(DEPTH)) begin
								count_q <= count_q + 1'b1;
							end
						end else if (count_q == '0) begin
							res_strobe_q <= 1'b1;
						end else begin
							unique case (req.req_type)
								REQ_TOP: state_q <= S_TOP;
								REQ_SORT: state_q <= S_SORT_NEXT;
								REQ_SHUFFLE: begin
									if (count_q == CW'(1)) begin
										res_strobe_q <= 1'b1;
									end else begin
										state_q <= S_SH_DRAW;
									end
								end
								default: begin
									state_q <= S_SCAN;
									pend_q  <= 1'b0;
								end
							endcase
						end
					end
				end
				S_TOP: begin
					res_strobe_q <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_SCAN: begin
					rv_s1 <= issue && !rem_hit;
					if (rv_s1 && op_q == REQ_DUMP) begin
						res_strobe_q <= 1'b1;
					end
					if (rv_s1 && op_q == REQ_FIND && rdata == key_q) begin
						pend_q <= 1'b1;
						if (pend_q) begin
							res_strobe_q <= 1'b1;
						end
					end
					if (rem_hit) begin
						state_q <= S_REM;
					end else if (drained) begin
						if (op_q == REQ_SORT) begin
							state_q <= (minpos_q != sort_i_q[AW-1:0]) ? S_SWAP_A
							                                          : S_SORT_NEXT;
						end else begin
							state_q <= S_IDLE;
							if (op_q != REQ_DUMP) begin
								res_strobe_q <= 1'b1;
							end
						end
					end
				end
				S_REM: begin
					rv_s1 <= issue;
					if (drained) begin
						count_q      <= count_q - 1'b1;
						res_strobe_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SORT_NEXT: begin
					if (sort_i_q + 1'b1 < count_q) begin
						state_q <= S_SCAN;
					end else begin
						res_strobe_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SWAP_A: state_q <= S_SWAP_B;
				S_SWAP_B: state_q <= S_SORT_NEXT;
				S_SH_DRAW: begin
					rng_q   <= draw;
					state_q <= S_SH_MOD;
				end
				S_SH_MOD: begin
					if (mod_done) begin
						if (AW'(mod_rem) != sh_i_q) begin
							state_q <= S_SH_RD1;
						end else if (sh_i_q == AW'(1)) begin
							res_strobe_q <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_SH_DRAW;
						end
					end
				end
				S_SH_RD1: state_q <= S_SH_RD2;
				S_SH_RD2: state_q <= S_SH_WR1;
				S_SH_WR1: state_q <= S_SH_WR2;
				S_SH_WR2: begin
					if (sh_i_q == AW'(1)) begin
						res_strobe_q <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_SH_DRAW;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q     <= req.req_type;
				key_q    <= key_new;
				ra_q     <= '0;
				sort_i_q <= '0;
				sh_i_q   <= AW'(count_q - 1'b1);
				res_q    <= '{status: idle_status, key_out: '0, position: '0,
				              live_count: idle_live, last: 1'b1};
			end
			S_TOP: begin
				res_q.key_out  <= 32'(rdata);
				res_q.position <= 6'(count_q - 1'b1);
			end
			S_SCAN: begin
				// a remove restarts the pointer just past the matching entry
				if (rem_hit) begin
					ra_q <= CW'(ri_s1) + 1'b1;
				end else if (issue) begin
					ra_q <= ra_q + 1'b1;
				end
				ri_s1 <= ra_q[AW-1:0];
				if (rv_s1) begin
					unique case (op_q)
						REQ_DUMP: begin
							res_q.key_out  <= 32'(rdata);
							res_q.position <= 6'(ri_s1);
							res_q.last     <= (CW'(ri_s1) + 1'b1 == count_q);
						end
						REQ_FIND: begin
							if (rdata == key_q) begin
								pend_pos_q     <= ri_s1;
								pend_key_q     <= rdata;
								res_q.key_out  <= 32'(pend_key_q);
								res_q.position <= 6'(pend_pos_q);
								res_q.last     <= 1'b0;
							end
						end
						REQ_REMOVE: begin
						end
						default: begin
							if (first_q || rdata < min_q) begin
								min_q    <= rdata;
								minpos_q <= ri_s1;
							end
							if (first_q) begin
								ival_q <= rdata;
							end
							first_q <= 1'b0;
						end
					endcase
				end
				if (drained) begin
					if (op_q == REQ_FIND) begin
						res_q.last <= 1'b1;
						if (pend_q) begin
							res_q.key_out  <= 32'(pend_key_q);
							res_q.position <= 6'(pend_pos_q);
						end else begin
							res_q.status <= STAT_NOT_FOUND;
						end
					end else if (op_q == REQ_REMOVE) begin
						res_q.status <= STAT_NOT_FOUND;
					end
				end
			end
			S_REM: begin
				if (issue) begin
					ra_q <= ra_q + 1'b1;
				end
				ri_s1            <= ra_q[AW-1:0];
				res_q.live_count <= 7'(count_q - 1'b1);
			end
			S_SORT_NEXT: begin
				ra_q    <= sort_i_q;
				first_q <= 1'b1;
			end
			S_SWAP_B: begin
				sort_i_q <= sort_i_q + 1'b1;
			end
			S_SH_MOD: begin
				r_q <= AW'(mod_rem);
				if (mod_done && AW'(mod_rem) == sh_i_q) begin
					sh_i_q <= sh_i_q - 1'b1;
				end
			end
			S_SH_RD2: vr_q <= rdata;
			S_SH_WR2: sh_i_q <= sh_i_q - 1'b1;
			default: begin
				ri_s1 <= ri_s1;
			end
		endcase
		if (state_q == S_SCAN && drained && op_q == REQ_SORT
		    && minpos_q == sort_i_q[AW-1:0]) begin
			sort_i_q <= sort_i_q + 1'b1;
		end
	end

	assign res_strobe = res_strobe_q;
	assign res        = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("live count beyond table depth");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> CW'(waddr) <= count_q)
		else $error("table write beyond live region");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res.status != STAT_OK |-> res.last)
		else $error("error result not final");

	a_no_cfg_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready)
		else $error("config accepted during a request");
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb
	import ktss_pkg::*;
;

	localparam int DEPTH = 64;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        res_strobe;
	res_t        res;

	key_table_shuffle_sort_search #(
		.DEPTH(DEPTH),
		.KEY_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.res_strobe(res_strobe),
		.res(res)
	);

	// clock, 8 units per period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// shadow copy of the table, the live count and the generator
	logic [31:0] shadow_keys [DEPTH];
	int          shadow_count;
	logic [31:0] shadow_rng;

	// words still owed by the block, oldest first
	res_t        owed_words [$];
	res_t        last_owed;
	int          mismatches;
	int          row_errs;
	int          words_seen;
	int          reqs_sent;
	int          cfg_writes;
	bit          all_sent;

	function automatic res_t mk_word(logic [1:0] st, logic [31:0] k, int pos, bit lst);
		res_t w;
		w.status     = st;
		w.key_out    = k;
		w.position   = pos[5:0];
		w.live_count = shadow_count[6:0];
		w.last       = lst;
		return w;
	endfunction

	// works out the words a request should produce and updates the shadow table
	task automatic predict_table(input req_t r);
		logic [31:0] draw;
		logic [31:0] tmp;
		int          n;
		int          j;
		int          m;
		int          hits;
		int          at;
		n = shadow_count;
		if (r.req_type == REQ_NONE) begin
			return;
		end
		if (r.req_type == REQ_APPEND) begin
			if (n >= DEPTH) begin
				owed_words.push_back(mk_word(STAT_FULL, '0, 0, 1'b1));
			end else begin
				shadow_keys[n] = r.key_in;
				shadow_count   = n + 1;
				owed_words.push_back(mk_word(STAT_OK, '0, 0, 1'b1));
			end
			return;
		end
		if (n == 0) begin
			owed_words.push_back(mk_word(STAT_EMPTY, '0, 0, 1'b1));
			return;
		end
		case (r.req_type)
			REQ_SHUFFLE: begin
				for (int i = n - 1; i >= 1; i--) begin
					draw = shadow_rng ^ (shadow_rng << 13);
					draw = draw ^ (draw >> 17);
					draw = draw ^ (draw << 5);
					shadow_rng = draw;
					j = int'(draw % (i + 1));
					tmp = shadow_keys[j];
					shadow_keys[j] = shadow_keys[i];
					shadow_keys[i] = tmp;
				end
				owed_words.push_back(mk_word(STAT_OK, '0, 0, 1'b1));
			end
			REQ_SORT: begin
				for (int i = 0; i + 1 < n; i++) begin
					m = i;
					for (int q = i + 1; q < n; q++)
						if (shadow_keys[q] < shadow_keys[m])
							m = q;
					tmp = shadow_keys[i];
					shadow_keys[i] = shadow_keys[m];
					shadow_keys[m] = tmp;
				end
				owed_words.push_back(mk_word(STAT_OK, '0, 0, 1'b1));
			end
			REQ_TOP: begin
				owed_words.push_back(mk_word(STAT_OK, shadow_keys[n-1], n - 1, 1'b1));
			end
			REQ_DUMP: begin
				for (int i = 0; i < n; i++)
					owed_words.push_back(mk_word(STAT_OK, shadow_keys[i], i, i + 1 == n));
			end
			REQ_FIND: begin
				hits = 0;
				for (int i = 0; i < n; i++)
					if (shadow_keys[i] == r.key_in)
						hits++;
				if (hits == 0) begin
					owed_words.push_back(mk_word(STAT_NOT_FOUND, '0, 0, 1'b1));
				end else begin
					for (int i = 0; i < n; i++)
						if (shadow_keys[i] == r.key_in) begin
							hits--;
							owed_words.push_back(mk_word(STAT_OK, shadow_keys[i], i,
								hits == 0));
						end
				end
			end
			default: begin
				at = -1;
				for (int i = n - 1; i >= 0; i--)
					if (shadow_keys[i] == r.key_in)
						at = i;
				if (at < 0) begin
					owed_words.push_back(mk_word(STAT_NOT_FOUND, '0, 0, 1'b1));
				end else begin
					for (int i = at; i + 1 < n; i++)
						shadow_keys[i] = shadow_keys[i+1];
					shadow_count = n - 1;
					owed_words.push_back(mk_word(STAT_OK, '0, 0, 1'b1));
				end
			end
		endcase
	endtask

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_strobe) begin
			words_seen <= words_seen + 1;
			if (owed_words.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected word %h", res);
			end else begin
				want = owed_words.pop_front();
				if (res !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("word mismatch: status %0d/%0d key %h/%h pos %0d/%0d cnt %0d/%0d last %0d/%0d",
							want.status, res.status, want.key_out, res.key_out,
							want.position, res.position, want.live_count, res.live_count,
							want.last, res.last);
				end
			end
		end
	end

	// sends one request word; at the end of each burst a random gap follows
	int burst_left;

	task automatic send_req(input req_t r);
		@(negedge clk);
		while (busy) @(negedge clk);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		predict_table(r);
		if (owed_words.size() > 0)
			last_owed = owed_words[$];
		reqs_sent++;
		@(negedge clk);
		start <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			repeat ($urandom_range(0, 20)) @(negedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// seed write, only with the block idle; req_type 7 gives no word, so allow a pause
	task automatic write_seed(input logic [31:0] seed);
		while (owed_words.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_rng = seed;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t mk_req(logic [2:0] op, logic [31:0] k);
		req_t r;
		r.req_type = op;
		r.key_in   = k;
		return r;
	endfunction

	// directed table; typed-in words where they are obvious, else the predictor
	typedef struct {
		logic [2:0]  op;
		logic [31:0] k;
		bit          typed;
		res_t        want;
	} dir_row_t;

	dir_row_t dir_rows [$];
	logic [31:0] pool [8];

	function automatic res_t lit(logic [1:0] st, logic [31:0] k, int pos, int cnt);
		res_t w;
		w.status     = st;
		w.key_out    = k;
		w.position   = pos[5:0];
		w.live_count = cnt[6:0];
		w.last       = 1'b1;
		return w;
	endfunction

	initial begin
		req_t        r;
		int          pick;
		logic [2:0]  op;
		logic [31:0] k;
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		shadow_count = 0;
		shadow_rng   = 32'd1;
		last_owed    = '0;
		mismatches   = 0;
		row_errs     = 0;
		words_seen   = 0;
		reqs_sent    = 0;
		cfg_writes   = 0;
		burst_left   = 0;
		all_sent     = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table replies, extremes of the key, unknown request, not found
		dir_rows.push_back('{REQ_TOP,     32'h0,        1, lit(STAT_EMPTY, 0, 0, 0)});
		dir_rows.push_back('{REQ_DUMP,    32'h0,        1, lit(STAT_EMPTY, 0, 0, 0)});
		dir_rows.push_back('{REQ_FIND,    32'hffffffff, 1, lit(STAT_EMPTY, 0, 0, 0)});
		dir_rows.push_back('{REQ_REMOVE,  32'h5,        1, lit(STAT_EMPTY, 0, 0, 0)});
		dir_rows.push_back('{REQ_SHUFFLE, 32'h0,        1, lit(STAT_EMPTY, 0, 0, 0)});
		dir_rows.push_back('{REQ_SORT,    32'h0,        1, lit(STAT_EMPTY, 0, 0, 0)});
		dir_rows.push_back('{REQ_NONE,    32'h1234,     0, '0});
		dir_rows.push_back('{REQ_APPEND,  32'hffffffff, 1, lit(STAT_OK, 0, 0, 1)});
		dir_rows.push_back('{REQ_SHUFFLE, 32'h0,        1, lit(STAT_OK, 0, 0, 1)});
		dir_rows.push_back('{REQ_SORT,    32'h0,        1, lit(STAT_OK, 0, 0, 1)});
		dir_rows.push_back('{REQ_TOP,     32'h0,        1, lit(STAT_OK, 32'hffffffff, 0, 1)});
		dir_rows.push_back('{REQ_APPEND,  32'h0,        1, lit(STAT_OK, 0, 0, 2)});
		dir_rows.push_back('{REQ_APPEND,  32'h0,        1, lit(STAT_OK, 0, 0, 3)});
		dir_rows.push_back('{REQ_APPEND,  32'h80000000, 1, lit(STAT_OK, 0, 0, 4)});
		dir_rows.push_back('{REQ_FIND,    32'h7,        1, lit(STAT_NOT_FOUND, 0, 0, 4)});
		dir_rows.push_back('{REQ_REMOVE,  32'h7,        1, lit(STAT_NOT_FOUND, 0, 0, 4)});
		dir_rows.push_back('{REQ_FIND,    32'h0,        0, '0});
		dir_rows.push_back('{REQ_DUMP,    32'h0,        0, '0});
		dir_rows.push_back('{REQ_SORT,    32'h0,        0, '0});
		dir_rows.push_back('{REQ_DUMP,    32'h0,        0, '0});
		dir_rows.push_back('{REQ_SHUFFLE, 32'h0,        0, '0});
		dir_rows.push_back('{REQ_REMOVE,  32'h0,        0, '0});
		dir_rows.push_back('{REQ_DUMP,    32'h0,        0, '0});
		foreach (dir_rows[i]) begin
			send_req(mk_req(dir_rows[i].op, dir_rows[i].k));
			if (dir_rows[i].typed && last_owed !== dir_rows[i].want) begin
				row_errs++;
				$display("table row %0d disagrees with predictor", i);
			end
		end

		// zero seed: every draw is zero
		write_seed(32'h0);
		send_req(mk_req(REQ_SHUFFLE, 0));
		send_req(mk_req(REQ_DUMP, 0));

		// fill to the top and try one more, at a maximum seed
		write_seed(32'hffffffff);
		while (shadow_count < DEPTH)
			send_req(mk_req(REQ_APPEND, $urandom()));
		send_req(mk_req(REQ_APPEND, 32'h1));
		send_req(mk_req(REQ_SHUFFLE, 0));
		send_req(mk_req(REQ_SORT, 0));
		send_req(mk_req(REQ_DUMP, 0));
		while (shadow_count > 0)
			send_req(mk_req(REQ_REMOVE, shadow_keys[$urandom_range(0, shadow_count - 1)]));

		// random part: keys from a small pool so finds and removes hit, a few wide ones
		for (int phase = 0; phase < 4; phase++) begin
			write_seed(phase == 0 ? 32'h1 : $urandom());
			foreach (pool[i])
				pool[i] = $urandom();
			for (int n = 0; n < 19; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)       op = REQ_APPEND;
				else if (pick < 50)  op = REQ_SHUFFLE;
				else if (pick < 58)  op = REQ_SORT;
				else if (pick < 66)  op = REQ_TOP;
				else if (pick < 72)  op = REQ_DUMP;
				else if (pick < 84)  op = REQ_FIND;
				else if (pick < 97)  op = REQ_REMOVE;
				else                 op = REQ_NONE;
				k = ($urandom_range(0, 4) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
				send_req(mk_req(op, k));
			end
		end
		all_sent = 1'b1;

		while (owed_words.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("requests sent %0d, words checked %0d, seed writes %0d",
			reqs_sent, words_seen, cfg_writes);
		$display("covered empty, full, not found, zero and extreme seeds, unknown requests");
		if (mismatches == 0 && row_errs == 0 && owed_words.size() == 0) begin
			$display("key_table_shuffle_sort_search regression: pass");
		end else begin
			$display("key_table_shuffle_sort_search regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("key_table_shuffle_sort_search regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
